// ----- hdl/ppd_pkg.sv -----
// Shared types and defaults for the palette pixel doubler.
// No dependencies; imported by the top level, ppd_position and ppd_doubler.
`default_nettype none

package ppd_pkg;

    localparam int SRC_WIDTH_DEF      = 160;
    localparam int NTSC_ROWS_DEF      = 210;
    localparam int PAL_ROWS_DEF       = 250;
    localparam int SHOWN_ROWS_DEF     = 240;
    localparam int ROWS_PER_CHUNK_DEF = 5;
    localparam int PALETTE_DEPTH_DEF  = 256;

    localparam int COLOR_W = 16;
    localparam int INDEX_W = 8;
    localparam int ROW_W   = 8;
    localparam int CHUNK_W = 3;

    // Position of one pixel within the frame
    typedef struct packed {
        logic shown;
        logic chunk_end;
        logic frame_end;
    } pix_info_t;

    function automatic logic [COLOR_W-1:0] byte_swap(input logic [COLOR_W-1:0] c);
        byte_swap = {c[7:0], c[15:8]};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/palette_pixel_doubler.sv -----
// Top level of the palette pixel doubler: palette store, position counters, output.
// Depends on ppd_pkg, ppd_ram, ppd_position and ppd_doubler.
//
// Use:
//   Input channel (in_valid/in_ready) carries one item per handshake. With func 0
//   the item writes palette_color into palette entry palette_index and gives no
//   output. With func 1 it is one source pixel: its color is looked up, byte
//   swapped and sent twice on the output channel (out_valid/out_ready), the
//   second copy marked by last and, where it applies, chunk_end and frame_end.
//   Pixels in hidden rows of a PAL frame advance the counters and give nothing.
//   cfg_wr_en/cfg_wr_data write pal_mode; write it only while the block is idle.
// Order: an accepted pixel passes the lookup stage and then the output register
//   before its first copy is valid; the second copy is valid once the first is taken.
// Throughput: a shown pixel gives two words, one per cycle while out_ready is high;
//   palette writes and hidden pixels go at one per cycle while in_ready is high.
// Reset: counters and pal_mode clear, pipeline empties; palette contents are
//   undefined until written.
// Stall: a held output keeps its word; one looked-up pixel waits behind it in
//   the lookup stage, after which in_ready drops.
`default_nettype none

module palette_pixel_doubler #(
    parameter int SRC_WIDTH      = ppd_pkg::SRC_WIDTH_DEF,
    parameter int NTSC_ROWS      = ppd_pkg::NTSC_ROWS_DEF,
    parameter int PAL_ROWS       = ppd_pkg::PAL_ROWS_DEF,
    parameter int SHOWN_ROWS     = ppd_pkg::SHOWN_ROWS_DEF,
    parameter int ROWS_PER_CHUNK = ppd_pkg::ROWS_PER_CHUNK_DEF,
    parameter int PALETTE_DEPTH  = ppd_pkg::PALETTE_DEPTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic                         cfg_wr_data,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         func,
    input  wire logic [ppd_pkg::INDEX_W-1:0]  palette_index,
    input  wire logic [ppd_pkg::COLOR_W-1:0]  palette_color,
    input  wire logic [ppd_pkg::INDEX_W-1:0]  pixel_index,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [ppd_pkg::COLOR_W-1:0]  lcd_word,
    output logic                              chunk_end,
    output logic                              frame_end,
    output logic                              last
);

    import ppd_pkg::*;

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic               pal_mode_reg;
    logic               accept;
    logic               pix_accept;
    logic               wr_en;
    logic               rd_en;
    logic [COLOR_W-1:0] rd_data;
    pix_info_t          pos_info;

    logic               look_valid_reg, look_valid_next;
    logic               look_range_reg;
    pix_info_t          look_info_reg;
    logic               look_move;
    logic               out_free;
    logic [COLOR_W-1:0] look_word;

    assign look_move  = look_valid_reg && out_free;
    assign in_ready   = !look_valid_reg || look_move;
    assign accept     = in_valid && in_ready;
    assign pix_accept = accept && func;
    assign wr_en      = accept && !func && ({1'b0, palette_index} < (INDEX_W+1)'(PALETTE_DEPTH));
    assign rd_en      = pix_accept && pos_info.shown;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pal_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            pal_mode_reg <= cfg_wr_data;
        end
    end

    ppd_position #(
        .SRC_WIDTH      (SRC_WIDTH),
        .NTSC_ROWS      (NTSC_ROWS),
        .PAL_ROWS       (PAL_ROWS),
        .SHOWN_ROWS     (SHOWN_ROWS),
        .ROWS_PER_CHUNK (ROWS_PER_CHUNK)
    ) u_position (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (pix_accept),
        .pal_mode (pal_mode_reg),
        .info     (pos_info)
    );

    ppd_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH),
        .AW    (AW)
    ) u_palette (
        .clk   (clk),
        .we    (wr_en),
        .waddr (palette_index[AW-1:0]),
        .wdata (palette_color),
        .re    (rd_en),
        .raddr (pixel_index[AW-1:0]),
        .rdata (rd_data)
    );

    // lookup stage: read data lands in the RAM output register alongside this
    always_comb
    begin
        look_valid_next = look_valid_reg;
        if (rd_en)
        begin
            look_valid_next = 1'b1;
        end
        else if (look_move)
        begin
            look_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_valid_reg <= 1'b0;
        end
        else
        begin
            look_valid_reg <= look_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            look_info_reg  <= pos_info;
            look_range_reg <= {1'b0, pixel_index} < (INDEX_W+1)'(PALETTE_DEPTH);
        end
    end

    // out-of-range index reads as black
    assign look_word = look_range_reg ? byte_swap(rd_data) : '0;

    ppd_doubler u_doubler (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (look_move),
        .word      (look_word),
        .info      (look_info_reg),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .lcd_word  (lcd_word),
        .chunk_end (chunk_end),
        .frame_end (frame_end),
        .last      (last)
    );

endmodule

`default_nettype wire

// ----- hdl/ppd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ppd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ppd_position.sv -----
// Column, row and chunk counters; flags each pixel with its frame position.
// Depends on ppd_pkg.
`default_nettype none

module ppd_position #(
    parameter int SRC_WIDTH      = ppd_pkg::SRC_WIDTH_DEF,
    parameter int NTSC_ROWS      = ppd_pkg::NTSC_ROWS_DEF,
    parameter int PAL_ROWS       = ppd_pkg::PAL_ROWS_DEF,
    parameter int SHOWN_ROWS     = ppd_pkg::SHOWN_ROWS_DEF,
    parameter int ROWS_PER_CHUNK = ppd_pkg::ROWS_PER_CHUNK_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic               pal_mode,
    output ppd_pkg::pix_info_t      info
);

    import ppd_pkg::*;

    localparam int COL_W     = (SRC_WIDTH > 1) ? $clog2(SRC_WIDTH) : 1;
    localparam int PAL_SHOWN = (SHOWN_ROWS > PAL_ROWS) ? PAL_ROWS : SHOWN_ROWS;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;

    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [CHUNK_W:0]   chunk_inc;
    logic [ROW_W-1:0]   shown_rows;
    logic [ROW_W-1:0]   frame_rows;
    logic               last_col;
    logic               chunk_full;
    logic               fend;

    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign chunk_inc  = {1'b0, chunk_reg} + 1'b1;
    assign shown_rows = pal_mode ? ROW_W'(PAL_SHOWN) : ROW_W'(NTSC_ROWS);
    assign frame_rows = pal_mode ? ROW_W'(PAL_ROWS) : ROW_W'(NTSC_ROWS);
    assign last_col   = col_inc >= (COL_W+1)'(SRC_WIDTH);
    assign chunk_full = chunk_inc >= (CHUNK_W+1)'(ROWS_PER_CHUNK);
    assign fend       = last_col && (row_inc == {1'b0, shown_rows});

    assign info.shown     = row_reg < shown_rows;
    assign info.frame_end = fend;
    assign info.chunk_end = last_col && (chunk_full || fend);

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        chunk_next = chunk_reg;
        if (step)
        begin
            if (!last_col)
            begin
                col_next = col_inc[COL_W-1:0];
            end
            else
            begin
                col_next = '0;
                if (info.shown && !chunk_full && !fend)
                begin
                    chunk_next = chunk_inc[CHUNK_W-1:0];
                end
                else
                begin
                    chunk_next = '0;
                end
                // wrap at the end of the frame, or if a mode change left us past it
                if (row_inc >= {1'b0, frame_rows})
                begin
                    row_next   = '0;
                    chunk_next = '0;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            chunk_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            chunk_reg <= chunk_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ppd_doubler.sv -----
// Output register that presents each looked-up word twice.
// Depends on ppd_pkg.
`default_nettype none

module ppd_doubler (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load,
    input  wire logic [ppd_pkg::COLOR_W-1:0]  word,
    input  wire ppd_pkg::pix_info_t           info,
    output logic                              free,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic      [ppd_pkg::COLOR_W-1:0]  lcd_word,
    output logic                              chunk_end,
    output logic                              frame_end,
    output logic                              last
);

    import ppd_pkg::*;

    logic               valid_reg, valid_next;
    logic               copy_reg, copy_next;
    logic [COLOR_W-1:0] word_reg;
    logic               cend_reg;
    logic               fend_reg;

    // free once the second copy leaves
    assign free = !valid_reg || (out_ready && copy_reg);

    always_comb
    begin
        valid_next = valid_reg;
        copy_next  = copy_reg;
        if (load)
        begin
            valid_next = 1'b1;
            copy_next  = 1'b0;
        end
        else if (valid_reg && out_ready)
        begin
            if (copy_reg)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                copy_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            copy_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            copy_reg  <= copy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= word;
            cend_reg <= info.chunk_end;
            fend_reg <= info.frame_end;
        end
    end

    assign out_valid = valid_reg;
    assign lcd_word  = word_reg;
    assign chunk_end = cend_reg && copy_reg;
    assign frame_end = fend_reg && copy_reg;
    assign last      = copy_reg;

endmodule

`default_nettype wire

// ----- hdl/ppd_checker.sv -----
// Port-level checks for the palette pixel doubler, bound to the top level.
// Depends only on the top-level port list.
`default_nettype none

module ppd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [15:0] lcd_word,
    input wire logic        chunk_end,
    input wire logic        frame_end,
    input wire logic        last
);

    // hold a stalled result
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(lcd_word) && $stable(last);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("stalled result changed");

    // second copy follows the first at once with the same word
    property p_second_copy;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && last && lcd_word == $past(lcd_word);
    endproperty
    a_second_copy: assert property (p_second_copy) else $error("second copy missing");

    // flags only ride on the second copy
    property p_flags_on_last;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !chunk_end && !frame_end;
    endproperty
    a_flags_on_last: assert property (p_flags_on_last) else $error("flag on first copy");

    // end of frame always closes a chunk
    property p_frame_chunk;
        @(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> chunk_end && last;
    endproperty
    a_frame_chunk: assert property (p_frame_chunk) else $error("frame end without chunk end");

endmodule

bind palette_pixel_doubler ppd_checker u_ppd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .lcd_word  (lcd_word),
    .chunk_end (chunk_end),
    .frame_end (frame_end),
    .last      (last)
);

`default_nettype wire

// ----- tb/palette_pixel_doubler_tb.sv -----
// Self-checking testbench for palette_pixel_doubler: palette loads, pixel scanout
// and mode changes mid-frame, checked word by word.
// Depends on ppd_pkg and the palette_pixel_doubler RTL.
`timescale 1ns / 100ps

module palette_pixel_doubler_tb;

    import ppd_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 1000;
    localparam int MAX_REPORTS   = 40;
    localparam int MIX_PHASES    = 4;
    localparam int MIX_ITEMS     = 393;

    typedef enum logic {
        FUNC_PALETTE = 1'b0,
        FUNC_PIXEL   = 1'b1
    } item_kind_t;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               chunk_end;
        logic               frame_end;
        logic               last;
    } lcd_result_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic               cfg_wr_data;
    logic               in_valid;
    logic               in_ready;
    logic               func;
    logic [INDEX_W-1:0] palette_index;
    logic [COLOR_W-1:0] palette_color;
    logic [INDEX_W-1:0] pixel_index;
    logic               out_valid;
    logic               out_ready;
    logic [COLOR_W-1:0] lcd_word;
    logic               chunk_end;
    logic               frame_end;
    logic               last;

    // Scanout predictor state
    logic [COLOR_W-1:0] palette_copy [PALETTE_DEPTH_DEF];
    int                 col_pos;
    int                 row_pos;
    int                 chunk_pos;
    bit                 mode_pal;

    lcd_result_t        pending_words [$];
    lcd_result_t        oldest_word;
    int                 fail_count;
    int                 quiet_cycles;
    bit                 steady;

    palette_pixel_doubler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .func          (func),
        .palette_index (palette_index),
        .palette_color (palette_color),
        .pixel_index   (pixel_index),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .lcd_word      (lcd_word),
        .chunk_end     (chunk_end),
        .frame_end     (frame_end),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic predict_scanout(input item_kind_t kind, input logic [INDEX_W-1:0] entry,
                                   input logic [COLOR_W-1:0] color,
                                   input logic [INDEX_W-1:0] pixel);
        int          frame_len;
        int          shown_len;
        bit          row_done;
        bit          shown;
        logic [COLOR_W-1:0] table_color;
        lcd_result_t first_copy;
        lcd_result_t second_copy;
        if (kind == FUNC_PALETTE)
        begin
            if (entry < PALETTE_DEPTH_DEF)
                palette_copy[entry] = color;
        end
        else
        begin
            frame_len = mode_pal ? PAL_ROWS_DEF : NTSC_ROWS_DEF;
            if (!mode_pal)
                shown_len = NTSC_ROWS_DEF;
            else
                shown_len = (SHOWN_ROWS_DEF > PAL_ROWS_DEF) ? PAL_ROWS_DEF : SHOWN_ROWS_DEF;
            row_done = (col_pos + 1 >= SRC_WIDTH_DEF);
            shown = (row_pos < shown_len);
            if (shown)
            begin
                table_color = (pixel < PALETTE_DEPTH_DEF) ? palette_copy[pixel] : '0;
                first_copy.color = {table_color[7:0], table_color[15:8]};
                first_copy.chunk_end = 1'b0;
                first_copy.frame_end = 1'b0;
                first_copy.last = 1'b0;
                second_copy = first_copy;
                // The last shown row always closes a chunk
                second_copy.frame_end = row_done && (row_pos + 1 == shown_len);
                second_copy.chunk_end = row_done &&
                    ((chunk_pos + 1 >= ROWS_PER_CHUNK_DEF) || second_copy.frame_end);
                second_copy.last = 1'b1;
                pending_words.push_back(first_copy);
                pending_words.push_back(second_copy);
            end
            if (!row_done)
                col_pos++;
            else
            begin
                col_pos = 0;
                if (shown && (chunk_pos + 1 < ROWS_PER_CHUNK_DEF) && (row_pos + 1 != shown_len))
                    chunk_pos++;
                else
                    chunk_pos = 0;
                row_pos++;
                // Wrap also covers a row count left past a shorter frame by a mode change
                if (row_pos >= frame_len || row_pos > 255)
                begin
                    row_pos = 0;
                    chunk_pos = 0;
                end
            end
        end
    endtask

    task automatic send_item(input item_kind_t kind, input logic [INDEX_W-1:0] entry,
                             input logic [COLOR_W-1:0] color,
                             input logic [INDEX_W-1:0] pixel);
        while (!steady && $urandom_range(99) < 16)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        func          <= kind;
        palette_index <= entry;
        palette_color <= color;
        pixel_index   <= pixel;
        do
            @(posedge clk);
        while (!in_ready);
        predict_scanout(kind, entry, color, pixel);
    endtask

    task automatic send_random_pixel();
        send_item(FUNC_PIXEL, INDEX_W'($urandom_range(255)),
                  COLOR_W'($urandom_range(16'hFFFF)), INDEX_W'($urandom_range(255)));
    endtask

    task automatic send_random_write();
        send_item(FUNC_PALETTE, INDEX_W'($urandom_range(255)),
                  COLOR_W'($urandom_range(16'hFFFF)), INDEX_W'($urandom_range(255)));
    endtask

    // Hold until every expected word is out and the pipeline has emptied
    task automatic wait_idle();
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_pal_mode(input bit mode);
        in_valid <= 1'b0;
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= mode;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        mode_pal = mode;
    endtask

    task automatic test_palette_load();
        set_pal_mode(1'b0);
        send_item(FUNC_PALETTE, 8'd0, 16'h0000, 8'hFF);
        send_item(FUNC_PALETTE, 8'd255, 16'hFFFF, 8'h00);
        send_item(FUNC_PALETTE, 8'd1, 16'h00FF, 8'h00);
        send_item(FUNC_PALETTE, 8'd2, 16'hFF00, 8'hFF);
        send_item(FUNC_PALETTE, 8'd3, 16'h1234, 8'h55);
        for (int i = 4; i < 255; i++)
            send_item(FUNC_PALETTE, INDEX_W'(i), COLOR_W'($urandom_range(16'hFFFF)),
                      INDEX_W'($urandom_range(255)));
    endtask

    task automatic test_directed();
        send_item(FUNC_PIXEL, 8'hFF, 16'hFFFF, 8'd0);
        send_item(FUNC_PIXEL, 8'h00, 16'h0000, 8'd255);
        send_item(FUNC_PIXEL, 8'h00, 16'h0000, 8'd1);
        send_item(FUNC_PIXEL, 8'hFF, 16'hFFFF, 8'd2);
        send_item(FUNC_PIXEL, 8'h00, 16'hFFFF, 8'd3);
        // Rewrite an entry and read it back at once
        send_item(FUNC_PALETTE, 8'd3, 16'hA5C3, 8'd3);
        send_item(FUNC_PIXEL, 8'd3, 16'h0000, 8'd3);
        send_item(FUNC_PALETTE, 8'd255, 16'h0000, 8'd255);
        send_item(FUNC_PIXEL, 8'd0, 16'hFFFF, 8'd255);
        send_item(FUNC_PALETTE, 8'd0, 16'hFFFF, 8'd0);
        send_item(FUNC_PIXEL, 8'd0, 16'h0000, 8'd0);
        send_item(FUNC_PALETTE, 8'd255, 16'hFFFF, 8'd0);
        send_item(FUNC_PIXEL, 8'd255, 16'h0000, 8'd255);
        steady = 1'b1;
        for (int i = 0; i < 10; i++)
            send_random_pixel();
        steady = 1'b0;
    endtask

    task automatic test_random_mix();
        for (int phase = 0; phase < MIX_PHASES; phase++)
        begin
            set_pal_mode(phase[0] ^ 1'($urandom_range(1)));
            steady = (phase == 2);
            for (int i = 0; i < MIX_ITEMS; i++)
            begin
                if ($urandom_range(99) < 20)
                    send_random_write();
                else
                    send_random_pixel();
            end
            steady = 1'b0;
        end
    endtask

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 16);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("unexpected item: lcd_word %h", lcd_word);
            end
            else
            begin
                oldest_word = pending_words.pop_front();
                if (lcd_word !== oldest_word.color)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("lcd_word: expected %h, got %h", oldest_word.color, lcd_word);
                end
                if (chunk_end !== oldest_word.chunk_end)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("chunk_end: expected %b, got %b", oldest_word.chunk_end,
                               chunk_end);
                end
                if (frame_end !== oldest_word.frame_end)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("frame_end: expected %b, got %b", oldest_word.frame_end,
                               frame_end);
                end
                if (last !== oldest_word.last)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $error("last: expected %b, got %b", oldest_word.last, last);
                end
            end
        end
    end

    // Watchdog: end the run when no item moves on either side for too long
    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("palette_pixel_doubler test failed");
        $finish;
    end

    initial
    begin
        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= 1'b0;
        in_valid      <= 1'b0;
        func          <= FUNC_PALETTE;
        palette_index <= '0;
        palette_color <= '0;
        pixel_index   <= '0;
        out_ready     <= 1'b0;
        col_pos       = 0;
        row_pos       = 0;
        chunk_pos     = 0;
        mode_pal      = 1'b0;
        fail_count    = 0;
        steady        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_palette_load();
        test_directed();
        test_random_mix();

        in_valid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("palette_pixel_doubler test passed");
        else
            $display("palette_pixel_doubler test failed");
        $finish;
    end

endmodule
